### hdl/ltp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the LED trail persistence block.
// Used by the channel interfaces and the top level; no dependencies.
package ltp_pkg;

    localparam int unsigned CH_W           = 8;
    localparam int unsigned PIX_W          = 3 * CH_W;
    localparam int unsigned IDX_W          = 16;
    localparam int unsigned CFG_IDX_W      = 3;
    localparam int unsigned MAX_PIXELS_DEF = 512;

    localparam logic [IDX_W-1:0] IDX_SAT = {IDX_W{1'b1}};

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam logic [1:0] MODE_CONST = 2'd0;
    localparam logic [1:0] MODE_BEAT  = 2'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE    = 3'd0,
        CFG_MODE      = 3'd1,
        CFG_FADE_RATE = 3'd2,
        CFG_MIN_FADE  = 3'd3,
        CFG_MAX_FADE  = 3'd4
    } cfg_idx_t;

endpackage : ltp_pkg
`default_nettype wire

### hdl/ltp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces of the LED trail persistence block:
// pixel input, pixel output and configuration write. Depends on ltp_pkg.

interface ltp_in_if import ltp_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            cmd;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
    logic            frame_end;
    logic            audio_valid;
    logic [CH_W-1:0] beat_phase;

    modport source (output valid, cmd, red_in, green_in, blue_in, frame_end,
                    audio_valid, beat_phase, input ready);
    modport sink (input valid, cmd, red_in, green_in, blue_in, frame_end,
                  audio_valid, beat_phase, output ready);
endinterface : ltp_in_if

interface ltp_out_if import ltp_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            frame_last;

    modport source (output valid, red_out, green_out, blue_out, frame_last,
                    input ready);
    modport sink (input valid, red_out, green_out, blue_out, frame_last,
                  output ready);
endinterface : ltp_out_if

interface ltp_cfg_if import ltp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CH_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface : ltp_cfg_if
`default_nettype wire

### hdl/ltp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Generic simple dual-port RAM: one write port, one read port with
// registered read data and a read enable. No dependencies.
module ltp_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 512,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : ltp_ram
`default_nettype wire

### hdl/led_trail_persistence.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the LED trail persistence block: frame store, fade and blend.
// Depends on ltp_pkg, the channel interfaces in ltp_if and ltp_ram.

// The block takes one RGB pixel transaction per cycle in frame order while
// ready is high, and returns one pixel transaction per pixel. The last output
// frame sits in a single-port-read, single-port-write RAM of MAX_PIXELS
// entries: a pixel reads its stored entry when it is accepted, and in the next
// stage the stored pixel is faded, combined by per-channel maximum with the
// incoming pixel and written back as the result leaves for the output
// register. Back-to-back pixels stream at one per cycle unless the output
// stalls; when two consecutive pixels touch the same entry (one-pixel frames)
// the written value is forwarded. A clear transaction gives no result; after
// it, and after reset, the block sweeps all MAX_PIXELS RAM entries to zero,
// one entry per cycle (starting once the pixel ahead of it has left the blend
// stage), and holds ready low meanwhile. Configuration writes are always taken
// and should be issued only while no pixel is in flight. The fade is latched
// at each frame's first pixel; pixels beyond MAX_PIXELS pass through unchanged.
module led_trail_persistence
    import ltp_pkg::*;
#(
    parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF
) (
    input wire logic  clk,
    input wire logic  rst_n,
    ltp_in_if.sink    pix_in,
    ltp_out_if.source pix_out,
    ltp_cfg_if.sink   cfg
);

    localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam logic [AW-1:0]    LAST_ADDR = AW'(MAX_PIXELS - 1);
    localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(MAX_PIXELS);

    // Fade of one channel: c * (256 - fade) >> 8. The result never exceeds c.
    function automatic logic [CH_W-1:0] dim_ch(input logic [CH_W-1:0] c,
                                               input logic [CH_W-1:0] f);
        logic [2*CH_W:0] p;
        p = (2*CH_W+1)'(c) * ((2*CH_W+1)'(256) - (2*CH_W+1)'(f));
        return p[2*CH_W-1:CH_W];
    endfunction

    function automatic logic [CH_W-1:0] max_ch(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    // Configuration registers.
    logic            enable_reg;
    logic [1:0]      mode_reg;
    logic [CH_W-1:0] fade_rate_reg;
    logic [CH_W-1:0] min_fade_reg;
    logic [CH_W-1:0] max_fade_reg;

    // Frame tracking.
    logic             hist_valid_reg, hist_valid_next;
    logic             frame_hist_reg, frame_hist_next;
    logic [CH_W-1:0]  frame_fade_reg, frame_fade_next;
    logic [IDX_W-1:0] pix_idx_reg, pix_idx_next;

    // RAM clearing sweep.
    logic          clr_busy_reg, clr_busy_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    // Blend stage.
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_store_reg;
    logic             s1_blend_reg;
    logic             s1_fwd_reg;
    logic [AW-1:0]    s1_addr_reg;
    logic [CH_W-1:0]  s1_fade_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [PIX_W-1:0] s1_fwd_data_reg;
    logic             s1_last_reg;

    // Output register.
    logic             out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] out_pix_reg;
    logic             out_last_reg;

    logic in_accept, pix_accept, clr_accept, advance, sweep_we;
    logic is_first, cur_hist, cur_store;
    logic [CH_W-1:0]  cur_fade, beat_fade;
    logic [AW-1:0]    cur_addr;
    logic [PIX_W-1:0] ram_rdata, prev_pix, blend_pix;

    // Beat fade: min + trunc((max - min) * (256 - phase) / 256), mod 256.
    logic signed [CH_W:0]     fade_diff;
    logic signed [CH_W+1:0]   phase_w;
    logic signed [2*CH_W+2:0] fade_prod;
    logic signed [2*CH_W+2:0] fade_adj;
    logic [CH_W-1:0]          fade_q;

    always_comb
    begin
        fade_diff = $signed({1'b0, max_fade_reg}) - $signed({1'b0, min_fade_reg});
        phase_w   = $signed((CH_W+2)'(256) - (CH_W+2)'(pix_in.beat_phase));
        fade_prod = (2*CH_W+3)'(fade_diff) * (2*CH_W+3)'(phase_w);
        // Division by 256 rounds toward zero, so negative products get a bias.
        fade_adj  = fade_prod[2*CH_W+2] ? fade_prod + (2*CH_W+3)'(255) : fade_prod;
        fade_q    = fade_adj[2*CH_W-1:CH_W];
        beat_fade = min_fade_reg + fade_q;
    end

    // Handshakes. The output register parts the blend stage from the sink.
    assign advance    = s1_valid_reg && (!out_valid_reg || pix_out.ready);
    assign pix_in.ready = !clr_busy_reg && (!s1_valid_reg || advance);
    assign in_accept  = pix_in.valid && pix_in.ready;
    assign pix_accept = in_accept && (pix_in.cmd == CMD_PIXEL);
    assign clr_accept = in_accept && (pix_in.cmd == CMD_CLEAR);
    assign cfg.ready  = 1'b1;

    // Per-pixel decisions taken at acceptance.
    always_comb
    begin
        is_first  = (pix_idx_reg == '0);
        cur_fade  = frame_fade_reg;
        cur_hist  = frame_hist_reg;
        if (is_first)
        begin
            cur_fade = (mode_reg == MODE_BEAT && pix_in.audio_valid) ? beat_fade
                                                                     : fade_rate_reg;
            cur_hist = hist_valid_reg;
        end
        cur_store = enable_reg && ({1'b0, pix_idx_reg} < DEPTH_EXT);
        cur_addr  = pix_idx_reg[AW-1:0];
    end

    // Blend stage: fade the stored pixel and keep the brighter channel.
    always_comb
    begin
        prev_pix  = s1_fwd_reg ? s1_fwd_data_reg : ram_rdata;
        blend_pix = s1_pix_reg;
        if (s1_blend_reg)
        begin
            blend_pix[3*CH_W-1:2*CH_W] = max_ch(s1_pix_reg[3*CH_W-1:2*CH_W],
                                                dim_ch(prev_pix[3*CH_W-1:2*CH_W],
                                                       s1_fade_reg));
            blend_pix[2*CH_W-1:CH_W]   = max_ch(s1_pix_reg[2*CH_W-1:CH_W],
                                                dim_ch(prev_pix[2*CH_W-1:CH_W],
                                                       s1_fade_reg));
            blend_pix[CH_W-1:0]        = max_ch(s1_pix_reg[CH_W-1:0],
                                                dim_ch(prev_pix[CH_W-1:0], s1_fade_reg));
        end
    end

    // Control next-state logic.
    always_comb
    begin
        hist_valid_next = hist_valid_reg;
        frame_hist_next = frame_hist_reg;
        frame_fade_next = frame_fade_reg;
        pix_idx_next    = pix_idx_reg;
        clr_busy_next   = clr_busy_reg;
        clr_cnt_next    = clr_cnt_reg;
        sweep_we        = clr_busy_reg && !s1_valid_reg;

        if (sweep_we)
        begin
            if (clr_cnt_reg == LAST_ADDR)
            begin
                clr_busy_next = 1'b0;
                clr_cnt_next  = '0;
            end
            else
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
            end
        end

        if (clr_accept)
        begin
            hist_valid_next = 1'b0;
            frame_hist_next = 1'b0;
            pix_idx_next    = '0;
            clr_busy_next   = 1'b1;
            clr_cnt_next    = '0;
        end
        else if (pix_accept)
        begin
            frame_fade_next = cur_fade;
            frame_hist_next = cur_hist;
            if (pix_in.frame_end)
            begin
                if (enable_reg)
                begin
                    hist_valid_next = 1'b1;
                end
                pix_idx_next = '0;
            end
            else if (pix_idx_reg != IDX_SAT)
            begin
                pix_idx_next = pix_idx_reg + IDX_W'(1);
            end
        end

        s1_valid_next = pix_accept || (s1_valid_reg && !advance);

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (pix_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b1;
            mode_reg       <= MODE_CONST;
            fade_rate_reg  <= '0;
            min_fade_reg   <= '0;
            max_fade_reg   <= '0;
            hist_valid_reg <= 1'b0;
            frame_hist_reg <= 1'b0;
            frame_fade_reg <= '0;
            pix_idx_reg    <= '0;
            clr_busy_reg   <= 1'b1;
            clr_cnt_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_ENABLE:    enable_reg    <= cfg.data[0];
                    CFG_MODE:      mode_reg      <= cfg.data[1:0];
                    CFG_FADE_RATE: fade_rate_reg <= cfg.data;
                    CFG_MIN_FADE:  min_fade_reg  <= cfg.data;
                    CFG_MAX_FADE:  max_fade_reg  <= cfg.data;
                    default:       ;
                endcase
            end
            hist_valid_reg <= hist_valid_next;
            frame_hist_reg <= frame_hist_next;
            frame_fade_reg <= frame_fade_next;
            pix_idx_reg    <= pix_idx_next;
            clr_busy_reg   <= clr_busy_next;
            clr_cnt_reg    <= clr_cnt_next;
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            s1_store_reg <= cur_store;
            s1_blend_reg <= cur_store && cur_hist;
            s1_addr_reg  <= cur_addr;
            s1_fade_reg  <= cur_fade;
            s1_pix_reg   <= {pix_in.red_in, pix_in.green_in, pix_in.blue_in};
            s1_last_reg  <= pix_in.frame_end;
            // The pixel ahead writes the entry this one reads in the same cycle.
            s1_fwd_reg   <= cur_store && s1_valid_reg && s1_store_reg &&
                            (s1_addr_reg == cur_addr);
            s1_fwd_data_reg <= blend_pix;
        end
        if (advance)
        begin
            out_pix_reg  <= blend_pix;
            out_last_reg <= s1_last_reg;
        end
    end

    ltp_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_PIXELS)
    ) u_frame_ram (
        .clk   (clk),
        .we    (sweep_we || (advance && s1_store_reg)),
        .waddr (sweep_we ? clr_cnt_reg : s1_addr_reg),
        .wdata (sweep_we ? '0 : blend_pix),
        .re    (pix_accept && cur_store),
        .raddr (cur_addr),
        .rdata (ram_rdata)
    );

    assign pix_out.valid      = out_valid_reg;
    assign pix_out.red_out    = out_pix_reg[3*CH_W-1:2*CH_W];
    assign pix_out.green_out  = out_pix_reg[2*CH_W-1:CH_W];
    assign pix_out.blue_out   = out_pix_reg[CH_W-1:0];
    assign pix_out.frame_last = out_last_reg;

    // The sweep and a pixel write never compete for the write port.
    a_sweep_alone: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_we |-> !(advance && s1_store_reg))
        else $error("clearing sweep overlaps a pixel write");

    // A clear transaction restarts framing and drops history.
    a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
        clr_accept |=> (!hist_valid_reg && !frame_hist_reg && pix_idx_reg == '0 &&
                        clr_busy_reg))
        else $error("clear did not reset frame state");

    // A frame end sends the next pixel back to the first entry.
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_accept && pix_in.frame_end) |=> (pix_idx_reg == '0))
        else $error("pixel index did not wrap at frame end");

    // A pixel that reached the blend stage leaves it before anything new enters.
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_addr_reg)))
        else $error("blend stage lost a stalled pixel");

endmodule : led_trail_persistence
`default_nettype wire

### test/led_trail_persistence_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for led_trail_persistence: directed rows, then random frames.
// Results are checked against an in-bench model of fade and blend, or a typed-in value.
// Depends on ltp_pkg, the channel interfaces in ltp_if and the top level.
module led_trail_persistence_tb;
    import ltp_pkg::*;

    // The default store depth of the block. After reset and after each
    // clear the block sweeps this many entries, so every settle is sized from it.
    localparam int unsigned DEPTH       = MAX_PIXELS_DEF;
    localparam int unsigned SETTLE      = DEPTH + 16;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned MAX_REPORTS = 10;

    // Mode values that the package does not name. Both of them behave
    // like constant mode.
    localparam logic [1:0] MODE_VELOCITY = 2'd2;
    localparam logic [1:0] MODE_SPARE    = 2'd3;

    typedef struct packed {
        logic            cmd;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            last;
        logic            audio;
        logic [CH_W-1:0] phase;
    } pix_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            last;
    } rgb_res_t;

    typedef enum logic [1:0] {
        ROW_PIX,
        ROW_CLEAR,
        ROW_CFG
    } row_kind_t;

    // One row of the directed table. A row marked pass_through carries a
    // result that is plainly the input pixel itself (first frame after
    // reset or clear, disabled, or a fully faded store), so it is typed in
    // rather than taken from the model below.
    typedef struct {
        row_kind_t       kind;
        cfg_idx_t        reg_sel;
        logic [CH_W-1:0] reg_val;
        pix_t            px;
        bit              pass_through;
    } row_t;

    logic clk;
    logic rst_n;

    ltp_in_if  pix_in ();
    ltp_out_if pix_out ();
    ltp_cfg_if cfg ();

    led_trail_persistence dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in),
        .pix_out (pix_out),
        .cfg     (cfg)
    );

    // Model of the block: the stored frame, the framing state and a copy
    // of every configuration register.
    logic [PIX_W-1:0] trail_mem [DEPTH];
    logic             hist_valid;
    logic             frame_hist;
    logic [IDX_W-1:0] pix_pos;
    logic [CH_W-1:0]  frame_fade;

    logic             set_enable;
    logic [1:0]       set_mode;
    logic [CH_W-1:0]  set_rate;
    logic [CH_W-1:0]  set_min;
    logic [CH_W-1:0]  set_max;

    // Blended pixels the block still owes us, oldest first.
    rgb_res_t blended_q [$];
    row_t     dir_rows [$];

    int  mismatches;
    int  stall_cycles;
    bit  idle_on;
    bit  dirty;
    int  out_hold;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Keeps the brighter of the incoming channel and the faded stored one.
    function automatic logic [CH_W-1:0] brighter(logic [CH_W-1:0] fresh,
                                                 logic [CH_W-1:0] stored);
        int dimmed;
        dimmed = (int'(stored) * (256 - int'(frame_fade))) >>> 8;
        return (dimmed > int'(fresh)) ? CH_W'(dimmed) : fresh;
    endfunction

    // Advances the model by one accepted transaction and queues the result
    // that it causes. A clear transaction causes none.
    task automatic trail_blend(input pix_t px);
        rgb_res_t         res;
        logic [PIX_W-1:0] old;
        int               span;
        int               step;
        if (px.cmd == CMD_CLEAR)
        begin
            foreach (trail_mem[i])
                trail_mem[i] = '0;
            hist_valid = 1'b0;
            frame_hist = 1'b0;
            pix_pos    = '0;
            return;
        end
        // The fade and the history flag are latched at the frame's first
        // pixel. In beat mode the span may be negative, and the division
        // then rounds toward zero before the sum wraps to eight bits.
        if (pix_pos == '0)
        begin
            if (set_mode == MODE_BEAT && px.audio)
            begin
                span = int'(set_max) - int'(set_min);
                step = (span * (256 - int'(px.phase))) / 256;
                frame_fade = CH_W'(int'(set_min) + step);
            end
            else
            begin
                frame_fade = set_rate;
            end
            frame_hist = hist_valid;
        end
        res = {px.red, px.green, px.blue, px.last};
        // Pixels beyond the store and pixels while disabled pass through.
        if (set_enable && pix_pos < DEPTH)
        begin
            if (frame_hist)
            begin
                old = trail_mem[pix_pos];
                res.red   = brighter(res.red, old[23:16]);
                res.green = brighter(res.green, old[15:8]);
                res.blue  = brighter(res.blue, old[7:0]);
            end
            trail_mem[pix_pos] = {res.red, res.green, res.blue};
        end
        blended_q.push_back(res);
        // A frame end closes the frame; only an enabled one arms history.
        // A frame that never ends holds its index at the top value.
        if (px.last)
        begin
            if (set_enable)
                hist_valid = 1'b1;
            pix_pos = '0;
        end
        else if (pix_pos != IDX_SAT)
        begin
            pix_pos = pix_pos + 1'b1;
        end
    endtask

    function automatic void add_cfg(cfg_idx_t sel, logic [CH_W-1:0] val);
        row_t r;
        r.kind         = ROW_CFG;
        r.reg_sel      = sel;
        r.reg_val      = val;
        r.px           = '0;
        r.pass_through = 1'b0;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_pix(logic [CH_W-1:0] red, logic [CH_W-1:0] green,
                                    logic [CH_W-1:0] blue, logic last,
                                    logic audio, logic [CH_W-1:0] phase,
                                    bit pass_through);
        row_t r;
        r.kind         = ROW_PIX;
        r.reg_sel      = CFG_ENABLE;
        r.reg_val      = '0;
        r.px           = {CMD_PIXEL, red, green, blue, last, audio, phase};
        r.pass_through = pass_through;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_clear();
        row_t r;
        r.kind         = ROW_CLEAR;
        r.reg_sel      = CFG_ENABLE;
        r.reg_val      = '0;
        r.px           = {CMD_CLEAR, 8'h5A, 8'hA5, 8'hFF, 1'b1, 1'b1, 8'hFF};
        r.pass_through = 1'b0;
        dir_rows.push_back(r);
    endfunction

    // Channel or fade value with the extremes well represented.
    function automatic logic [CH_W-1:0] rand_level();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return CH_W'($urandom_range(0, 255));
    endfunction

    function automatic pix_t rand_pixel(logic last);
        pix_t px;
        px.cmd   = CMD_PIXEL;
        px.red   = rand_level();
        px.green = rand_level();
        px.blue  = rand_level();
        px.last  = last;
        px.audio = 1'($urandom_range(0, 1));
        px.phase = rand_level();
        return px;
    endfunction

    function automatic pix_t rand_clear();
        pix_t px;
        px     = rand_pixel(1'($urandom_range(0, 1)));
        px.cmd = CMD_CLEAR;
        return px;
    endfunction

    // Drives one pixel or clear transaction. Inputs change on the falling
    // edge; acceptance is seen at the rising edge. Valid stays high from
    // one transaction to the next unless a random gap drops it first.
    task automatic send_item(input pix_t px, input bit pass_through);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 15);
            @(negedge clk);
            pix_in.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        pix_in.cmd         <= px.cmd;
        pix_in.red_in      <= px.red;
        pix_in.green_in    <= px.green;
        pix_in.blue_in     <= px.blue;
        pix_in.frame_end   <= px.last;
        pix_in.audio_valid <= px.audio;
        pix_in.beat_phase  <= px.phase;
        pix_in.valid       <= 1'b1;
        do
            @(posedge clk);
        while (!pix_in.ready);
        trail_blend(px);
        if (pass_through && px.cmd == CMD_PIXEL)
            blended_q[blended_q.size() - 1] = {px.red, px.green, px.blue, px.last};
        dirty = 1'b1;
    endtask

    // Stops sending and waits until every owed result has come back.
    task automatic drain();
        if (pix_in.valid)
        begin
            @(negedge clk);
            pix_in.valid <= 1'b0;
        end
        while (blended_q.size() != 0)
            @(posedge clk);
    endtask

    // Register writes happen only with the block idle. A trailing clear
    // may still be sweeping the store when the last result has left, so
    // the write also waits out one full sweep.
    task automatic write_reg(input cfg_idx_t sel, input logic [CH_W-1:0] val);
        if (dirty)
        begin
            drain();
            repeat (SETTLE) @(posedge clk);
            dirty = 1'b0;
        end
        @(negedge clk);
        cfg.index <= sel;
        cfg.data  <= val;
        cfg.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg.ready);
        case (sel)
            CFG_ENABLE:    set_enable = val[0];
            CFG_MODE:      set_mode   = val[1:0];
            CFG_FADE_RATE: set_rate   = val;
            CFG_MIN_FADE:  set_min    = val;
            CFG_MAX_FADE:  set_max    = val;
            default:       ;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // One well-formed frame with random content. Now and then a clear
    // cuts it short, which leaves a frame that never ended.
    task automatic send_frame(input int len);
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 79) == 0)
            begin
                send_item(rand_clear(), 1'b0);
                return;
            end
            send_item(rand_pixel(k == len - 1), 1'b0);
        end
    endtask

    // Output side: ready drops in random bursts while idling is on.
    initial
    begin
        pix_out.ready = 1'b0;
        out_hold = 0;
        forever
        begin
            @(negedge clk);
            if (out_hold > 0)
            begin
                pix_out.ready <= 1'b0;
                out_hold--;
            end
            else if (rst_n && idle_on && $urandom_range(0, 5) == 0)
            begin
                pix_out.ready <= 1'b0;
                out_hold = $urandom_range(1, 15) - 1;
            end
            else
            begin
                pix_out.ready <= rst_n;
            end
        end
    end

    // Scoreboard: each output transaction against the oldest expectation.
    always @(posedge clk)
    begin
        rgb_res_t want;
        rgb_res_t got;
        if (rst_n && pix_out.valid && pix_out.ready)
        begin
            got = {pix_out.red_out, pix_out.green_out, pix_out.blue_out,
                   pix_out.frame_last};
            if (blended_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected output r=%02h g=%02h b=%02h last=%0b",
                             $realtime, got.red, got.green, got.blue, got.last);
            end
            else
            begin
                want = blended_q.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: expected r=%02h g=%02h b=%02h last=%0b, %s",
                                 $realtime, want.red, want.green, want.blue, want.last,
                                 $sformatf("got r=%02h g=%02h b=%02h last=%0b",
                                           got.red, got.green, got.blue, got.last));
                end
            end
        end
    end

    // Watchdog: too many cycles without any transaction on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (pix_in.valid && pix_in.ready) ||
            (pix_out.valid && pix_out.ready) || (cfg.valid && cfg.ready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int budget;
        int len;
        int pick;

        rst_n              = 1'b0;
        pix_in.valid       = 1'b0;
        pix_in.cmd         = CMD_PIXEL;
        pix_in.red_in      = '0;
        pix_in.green_in    = '0;
        pix_in.blue_in     = '0;
        pix_in.frame_end   = 1'b0;
        pix_in.audio_valid = 1'b0;
        pix_in.beat_phase  = '0;
        cfg.valid          = 1'b0;
        cfg.index          = CFG_ENABLE;
        cfg.data           = '0;

        foreach (trail_mem[i])
            trail_mem[i] = '0;
        hist_valid   = 1'b0;
        frame_hist   = 1'b0;
        pix_pos      = '0;
        frame_fade   = '0;
        set_enable   = 1'b1;
        set_mode     = MODE_CONST;
        set_rate     = '0;
        set_min      = '0;
        set_max      = '0;
        mismatches   = 0;
        stall_cycles = 0;
        idle_on      = 1'b1;
        dirty        = 1'b0;

        // Directed table. The first frame after reset has no history, so
        // it passes through whatever the fade.
        add_pix(8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
        add_pix(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1);
        add_pix(8'h12, 8'h34, 8'h56, 1'b1, 1'b0, 8'h00, 1'b1);
        // Full fade wipes the stored frame, so dark input stays dark.
        add_cfg(CFG_FADE_RATE, 8'hFF);
        add_pix(8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
        add_pix(8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1);
        add_pix(8'h01, 8'h01, 8'h01, 1'b1, 1'b0, 8'h00, 1'b1);
        add_cfg(CFG_FADE_RATE, 8'h40);
        add_pix(8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
        add_pix(8'h10, 8'h20, 8'h30, 1'b1, 1'b0, 8'h00, 1'b0);
        // Beat mode at both ends of the phase, then with the span negative.
        add_cfg(CFG_MODE, {6'd0, MODE_BEAT});
        add_cfg(CFG_MIN_FADE, 8'h00);
        add_cfg(CFG_MAX_FADE, 8'hFF);
        add_pix(8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0);
        add_pix(8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0);
        add_pix(8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'hFF, 1'b0);
        add_pix(8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0);
        add_cfg(CFG_MIN_FADE, 8'hFF);
        add_cfg(CFG_MAX_FADE, 8'h00);
        add_pix(8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'h80, 1'b0);
        add_pix(8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0);
        // Beat mode without audio falls back to the fade rate.
        add_pix(8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
        add_pix(8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0);
        // Velocity and the unused mode act as constant; one-pixel frames
        // back to back hit the same store entry.
        add_cfg(CFG_MODE, {6'd0, MODE_VELOCITY});
        add_pix(8'h80, 8'h00, 8'hFF, 1'b1, 1'b1, 8'h00, 1'b0);
        add_cfg(CFG_MODE, {6'd0, MODE_SPARE});
        add_pix(8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0);
        add_pix(8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0);
        // Disabled: pass through, and a clear while disabled. The frame
        // end seen while disabled must not arm history, so the next
        // enabled frame passes through as well.
        add_cfg(CFG_ENABLE, 8'h00);
        add_pix(8'h07, 8'h08, 8'h09, 1'b0, 1'b0, 8'h00, 1'b1);
        add_pix(8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b1);
        add_clear();
        add_pix(8'hAA, 8'h55, 8'hAA, 1'b1, 1'b0, 8'h00, 1'b1);
        add_cfg(CFG_ENABLE, 8'h01);
        add_pix(8'hFF, 8'h00, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b1);
        add_pix(8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_reg(dir_rows[i].reg_sel, dir_rows[i].reg_val);
            else
                send_item(dir_rows[i].px, dir_rows[i].pass_through);
        end

        // Random phases, each under a fresh configuration. Every third
        // phase runs without idling on either side.
        for (int ph = 0; ph < 8; ph++)
        begin
            pick = $urandom_range(0, 5);
            write_reg(CFG_ENABLE, {7'd0, 1'($urandom_range(0, 4) != 0)});
            write_reg(CFG_MODE, {6'd0, (pick > 3) ? MODE_BEAT : 2'(pick)});
            write_reg(CFG_FADE_RATE, rand_level());
            write_reg(CFG_MIN_FADE, rand_level());
            write_reg(CFG_MAX_FADE, rand_level());
            idle_on = (ph % 3 != 2);
            // One frame longer than the store, so its tail passes through.
            // No clear cuts it short.
            if (ph == 3)
            begin
                for (int k = 0; k < int'(DEPTH) + 18; k++)
                    send_item(rand_pixel(k == int'(DEPTH) + 17), 1'b0);
            end
            budget = 0;
            while (budget < 30)
            begin
                pick = $urandom_range(0, 39);
                if (pick == 0)
                begin
                    send_item(rand_clear(), 1'b0);
                    budget++;
                end
                else if (pick == 1)
                begin
                    drain();
                end
                else
                begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48)
                                                      : $urandom_range(1, 12);
                    send_frame(len);
                    budget += len;
                end
            end
        end

        // Last part, no idling: short frames back to back.
        idle_on = 1'b0;
        write_reg(CFG_ENABLE, 8'h01);
        write_reg(CFG_MODE, {6'd0, MODE_CONST});
        write_reg(CFG_FADE_RATE, rand_level());
        for (int f = 0; f < 10; f++)
            send_frame($urandom_range(1, 6));

        drain();
        repeat (16) @(posedge clk);
        if (blended_q.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule : led_trail_persistence_tb
